>>> rtl/i2crm_pkg.sv
package i2crm_pkg;

    // Fixed field widths
    localparam int ACTION_W    = 2;
    localparam int REG_ADDR_W  = 24;
    localparam int COUNT_W     = 16;
    localparam int BYTE_W      = 8;
    localparam int DEV_ADDR_W  = 7;
    localparam int ADDR_BYTES_W = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 7;

    // Default saturation for the register address byte count
    localparam int MAX_ADDR_BYTES_DEF = 3;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_ADDRESS_BYTES = 1'd1;

    // One tick item
    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic [REG_ADDR_W-1:0] reg_address;
        logic [COUNT_W-1:0]    byte_count;
        logic [BYTE_W-1:0]     write_byte;
        logic                  write_valid;
        logic                  sda_in;
    } t_req;

    // One tick result
    typedef struct packed {
        logic              scl;
        logic              sda_release;
        logic [BYTE_W-1:0] read_byte;
        logic              read_valid;
        logic              last_read;
        logic              ack_bit;
        logic              ack_valid;
        logic              need_write_byte;
        logic              busy_res;
        logic              done_res;
    } t_res;

    // Configuration write
    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

>>> rtl/i2crm_channels_if.sv
// Tick channel into the block
interface i2crm_req_if;
    import i2crm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ACTION_W-1:0]   action;
    logic [REG_ADDR_W-1:0] reg_address;
    logic [COUNT_W-1:0]    byte_count;
    logic [BYTE_W-1:0]     write_byte;
    logic                  write_valid;
    logic                  sda_in;

    modport source (
        output valid, action, reg_address, byte_count, write_byte, write_valid, sda_in,
        input  ready
    );
    modport sink (
        input  valid, action, reg_address, byte_count, write_byte, write_valid, sda_in,
        output ready
    );
endinterface

// Result channel out of the block
interface i2crm_res_if;
    import i2crm_pkg::*;

    logic              valid;
    logic              ready;
    logic              scl;
    logic              sda_release;
    logic [BYTE_W-1:0] read_byte;
    logic              read_valid;
    logic              last_read;
    logic              ack_bit;
    logic              ack_valid;
    logic              need_write_byte;
    logic              busy_res;
    logic              done_res;

    modport source (
        output valid, scl, sda_release, read_byte, read_valid, last_read, ack_bit,
               ack_valid, need_write_byte, busy_res, done_res,
        input  ready
    );
    modport sink (
        input  valid, scl, sda_release, read_byte, read_valid, last_read, ack_bit,
               ack_valid, need_write_byte, busy_res, done_res,
        output ready
    );
endinterface

>>> rtl/i2c_register_master_top.sv
// I2C register master: each transaction on i_req is one bus tick carrying the sampled SDA
// level, and each transaction on o_res gives the SCL level and SDA drive for that tick with
// status. A tick is accepted every clock cycle while o_res is not stalled. The input
// register holds the tick, then the one-step sequencer loads its result into the result
// register for o_res. Results wait there while o_res is stalled, and the input register
// keeps taking ticks until both stages are full. Configuration (device address, number of
// register address bytes) is written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must do so only while no transaction is in flight, which the block does not enforce.
module i2c_register_master_top
    import i2crm_pkg::*;
#(
    parameter int MAX_ADDR_BYTES = MAX_ADDR_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    i2crm_req_if.sink             i_req,
    i2crm_res_if.source           o_res
);

    t_req    item;
    logic    item_valid;
    logic    item_ready;
    t_cfg_wr cfg;

    // Bundle the configuration write
    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    i2crm_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_item       (item),
        .o_item_valid (item_valid),
        .i_item_ready (item_ready)
    );

    i2crm_sequencer #(
        .MAX_ADDR_BYTES (MAX_ADDR_BYTES)
    ) u_sequencer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_item_ready (item_ready),
        .o_res        (o_res)
    );

endmodule

>>> rtl/i2crm_in_stage.sv
module i2crm_in_stage
    import i2crm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2crm_req_if.sink   i_req,
    output t_req        o_item,
    output logic        o_item_valid,
    input  logic        i_item_ready
);

    logic r_valid;
    t_req r_item;

    // Take a new transaction whenever the register is empty or moving on
    assign i_req.ready = !r_valid || i_item_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_valid <= i_req.valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_item.action      <= i_req.action;
            r_item.reg_address <= i_req.reg_address;
            r_item.byte_count  <= i_req.byte_count;
            r_item.write_byte  <= i_req.write_byte;
            r_item.write_valid <= i_req.write_valid;
            r_item.sda_in      <= i_req.sda_in;
        end
    end

    assign o_item       = r_item;
    assign o_item_valid = r_valid;

endmodule

>>> rtl/i2crm_sequencer.sv
module i2crm_sequencer
    import i2crm_pkg::*;
#(
    parameter int MAX_ADDR_BYTES = MAX_ADDR_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg_wr       i_cfg,
    input  t_req          i_item,
    input  logic          i_item_valid,
    output logic          o_item_ready,
    i2crm_res_if.source   o_res
);

    typedef enum logic [4:0] {
        ST_IDLE       = 5'd0,
        ST_TX_LOW     = 5'd1,
        ST_TX_HIGH    = 5'd2,
        ST_ACK_LOW    = 5'd3,
        ST_ACK_HIGH   = 5'd4,
        ST_WAIT_DATA  = 5'd5,
        ST_STOP_LOW   = 5'd6,
        ST_STOP_HIGH  = 5'd7,
        ST_STOP_END   = 5'd8,
        ST_MSTOP_LOW  = 5'd9,
        ST_MSTOP_HIGH = 5'd10,
        ST_MSTOP_END  = 5'd11,
        ST_RESTART    = 5'd12,
        ST_RX_LOW     = 5'd13,
        ST_RX_HIGH    = 5'd14,
        ST_MACK_LOW   = 5'd15,
        ST_MACK_HIGH  = 5'd16,
        ST_RTX_LOW    = 5'd17,
        ST_RTX_HIGH   = 5'd18,
        ST_RACK_LOW   = 5'd19,
        ST_RACK_HIGH  = 5'd20
    } t_step;

    // Configuration registers
    logic [DEV_ADDR_W-1:0]   r_dev_addr;
    logic [ADDR_BYTES_W-1:0] r_addr_bytes;

    // Sequencer state
    t_step                   r_step,       n_step;
    logic [3:0]              r_bit_idx,    n_bit_idx;
    logic [BYTE_W-1:0]       r_shift,      n_shift;
    logic [COUNT_W-1:0]      r_bytes_left, n_bytes_left;
    logic [ADDR_BYTES_W-1:0] r_abytes,     n_abytes;
    logic [REG_ADDR_W-1:0]   r_reg_addr,   n_reg_addr;
    logic                    r_is_read,    n_is_read;

    // Result register
    logic r_out_valid;
    t_res r_out, n_out;

    logic                    advance;
    logic [ADDR_BYTES_W-1:0] abytes_dec;
    logic [ADDR_BYTES_W-1:0] abytes_sat;
    logic [3:0]              bit_inc;
    logic [COUNT_W-1:0]      bytes_dec;
    logic                    last_byte;

    assign o_item_ready = !r_out_valid || o_res.ready;
    assign advance      = i_item_valid && o_item_ready;

    assign abytes_dec = r_abytes - 1'b1;
    assign bit_inc    = r_bit_idx + 4'd1;
    assign bytes_dec  = r_bytes_left - 1'b1;
    assign last_byte  = (r_bytes_left == COUNT_W'(1));
    assign abytes_sat = (int'(r_addr_bytes) > MAX_ADDR_BYTES) ?
                        ADDR_BYTES_W'(MAX_ADDR_BYTES) : r_addr_bytes;

    // Next state and line levels for one tick
    always_comb begin
        n_step       = r_step;
        n_bit_idx    = r_bit_idx;
        n_shift      = r_shift;
        n_bytes_left = r_bytes_left;
        n_abytes     = r_abytes;
        n_reg_addr   = r_reg_addr;
        n_is_read    = r_is_read;

        n_out                 = '0;
        n_out.scl             = 1'b1;
        n_out.sda_release     = 1'b1;
        n_out.busy_res        = 1'b1;

        unique case (r_step)
            ST_TX_LOW, ST_RTX_LOW: begin
                n_out.scl         = 1'b0;
                n_out.sda_release = r_shift[BYTE_W-1];
                n_step = (r_step == ST_TX_LOW) ? ST_TX_HIGH : ST_RTX_HIGH;
            end
            ST_TX_HIGH, ST_RTX_HIGH: begin
                n_out.sda_release = r_shift[BYTE_W-1];
                n_shift   = {r_shift[BYTE_W-2:0], 1'b0};
                n_bit_idx = bit_inc;
                if (bit_inc >= 4'd8) begin
                    n_step = (r_step == ST_TX_HIGH) ? ST_ACK_LOW : ST_RACK_LOW;
                end else begin
                    n_step = (r_step == ST_TX_HIGH) ? ST_TX_LOW : ST_RTX_LOW;
                end
            end
            ST_ACK_LOW, ST_RACK_LOW: begin
                n_out.scl = 1'b0;
                n_step = (r_step == ST_ACK_LOW) ? ST_ACK_HIGH : ST_RACK_HIGH;
            end
            ST_ACK_HIGH: begin
                n_out.ack_bit   = i_item.sda_in;
                n_out.ack_valid = 1'b1;
                // Next register address byte, else data phase, restart or stop
                if (r_abytes != '0) begin
                    n_abytes  = abytes_dec;
                    n_bit_idx = '0;
                    n_step    = ST_TX_LOW;
                    unique case (abytes_dec)
                        2'd0:    n_shift = r_reg_addr[7:0];
                        2'd1:    n_shift = r_reg_addr[15:8];
                        2'd2:    n_shift = r_reg_addr[23:16];
                        default: n_shift = '0;
                    endcase
                end else if (r_is_read) begin
                    n_step = ST_MSTOP_LOW;
                end else if (r_bytes_left != '0) begin
                    n_step = ST_WAIT_DATA;
                end else begin
                    n_step = ST_STOP_LOW;
                end
            end
            ST_RACK_HIGH: begin
                n_out.ack_bit   = i_item.sda_in;
                n_out.ack_valid = 1'b1;
                n_bit_idx = '0;
                n_shift   = '0;
                n_step    = (r_bytes_left != '0) ? ST_RX_LOW : ST_STOP_LOW;
            end
            ST_WAIT_DATA: begin
                // Hold SCL low until a write byte is offered
                n_out.scl             = 1'b0;
                n_out.need_write_byte = 1'b1;
                if (i_item.write_valid) begin
                    n_shift      = i_item.write_byte;
                    n_bytes_left = bytes_dec;
                    n_bit_idx    = '0;
                    n_step       = ST_TX_LOW;
                end
            end
            ST_STOP_LOW, ST_MSTOP_LOW: begin
                n_out.scl         = 1'b0;
                n_out.sda_release = 1'b0;
                n_step = (r_step == ST_STOP_LOW) ? ST_STOP_HIGH : ST_MSTOP_HIGH;
            end
            ST_STOP_HIGH, ST_MSTOP_HIGH: begin
                n_out.sda_release = 1'b0;
                n_step = (r_step == ST_STOP_HIGH) ? ST_STOP_END : ST_MSTOP_END;
            end
            ST_STOP_END: begin
                n_out.done_res = 1'b1;
                n_step = ST_IDLE;
            end
            ST_MSTOP_END: begin
                n_step = ST_RESTART;
            end
            ST_RESTART: begin
                n_out.sda_release = 1'b0;
                n_shift   = {r_dev_addr, 1'b1};
                n_bit_idx = '0;
                n_step    = ST_RTX_LOW;
            end
            ST_RX_LOW: begin
                n_out.scl = 1'b0;
                n_step = ST_RX_HIGH;
            end
            ST_RX_HIGH: begin
                n_shift   = {r_shift[BYTE_W-2:0], i_item.sda_in};
                n_bit_idx = bit_inc;
                n_step    = (bit_inc >= 4'd8) ? ST_MACK_LOW : ST_RX_LOW;
            end
            ST_MACK_LOW: begin
                // NAK on the final byte, ACK otherwise
                n_out.scl         = 1'b0;
                n_out.sda_release = last_byte;
                n_step = ST_MACK_HIGH;
            end
            ST_MACK_HIGH: begin
                n_out.last_read   = last_byte;
                n_out.sda_release = last_byte;
                n_out.read_byte   = r_shift;
                n_out.read_valid  = 1'b1;
                n_bytes_left = bytes_dec;
                n_bit_idx    = '0;
                n_shift      = '0;
                n_step       = (bytes_dec == '0) ? ST_STOP_LOW : ST_RX_LOW;
            end
            default: begin
                // Idle, or an unknown step
                n_step         = ST_IDLE;
                n_out.busy_res = 1'b0;
                if (i_item.action == ACT_READ || i_item.action == ACT_WRITE) begin
                    n_out.busy_res    = 1'b1;
                    n_out.sda_release = 1'b0;
                    n_is_read    = (i_item.action == ACT_READ);
                    n_reg_addr   = i_item.reg_address;
                    n_bytes_left = i_item.byte_count;
                    n_abytes     = abytes_sat;
                    n_shift      = {r_dev_addr, 1'b0};
                    n_bit_idx    = '0;
                    n_step       = ST_TX_LOW;
                end
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr   <= '0;
            r_addr_bytes <= ADDR_BYTES_W'(1);
        end else if (i_cfg.we) begin
            unique case (i_cfg.idx)
                CFG_DEVICE_ADDRESS:    r_dev_addr   <= i_cfg.data[DEV_ADDR_W-1:0];
                CFG_REG_ADDRESS_BYTES: r_addr_bytes <= i_cfg.data[ADDR_BYTES_W-1:0];
                default:               r_dev_addr   <= r_dev_addr;
            endcase
        end
    end

    // State advances once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= ST_IDLE;
            r_bit_idx    <= '0;
            r_shift      <= '0;
            r_bytes_left <= '0;
            r_abytes     <= '0;
            r_reg_addr   <= '0;
            r_is_read    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (advance) begin
                r_step       <= n_step;
                r_bit_idx    <= n_bit_idx;
                r_shift      <= n_shift;
                r_bytes_left <= n_bytes_left;
                r_abytes     <= n_abytes;
                r_reg_addr   <= n_reg_addr;
                r_is_read    <= n_is_read;
                r_out_valid  <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // Result payload, no reset
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.scl             = r_out.scl;
    assign o_res.sda_release     = r_out.sda_release;
    assign o_res.read_byte       = r_out.read_byte;
    assign o_res.read_valid      = r_out.read_valid;
    assign o_res.last_read       = r_out.last_read;
    assign o_res.ack_bit         = r_out.ack_bit;
    assign o_res.ack_valid       = r_out.ack_valid;
    assign o_res.need_write_byte = r_out.need_write_byte;
    assign o_res.busy_res        = r_out.busy_res;
    assign o_res.done_res        = r_out.done_res;

endmodule

>>> tb/i2c_register_master_top_tb.sv
`timescale 1ns / 1ps

module i2c_register_master_top_tb;
    import i2crm_pkg::*;

    // Action code with no meaning of its own, behaves as a plain tick
    localparam logic [ACTION_W-1:0] ACT_RSVD = 2'd3;
    localparam int MAX_AB   = MAX_ADDR_BYTES_DEF;
    localparam int DIR_N    = 25;
    localparam int PHASES   = 6;
    localparam int PHASE_IT = 270;

    // Sequencer steps of the bus engine, mirrored for prediction
    typedef enum logic [4:0] {
        BUS_IDLE, BUS_TX_LO, BUS_TX_HI, BUS_ACK_LO, BUS_ACK_HI, BUS_WAIT,
        BUS_STOP_LO, BUS_STOP_HI, BUS_STOP_END, BUS_MSTOP_LO, BUS_MSTOP_HI,
        BUS_MSTOP_END, BUS_RESTART, BUS_RX_LO, BUS_RX_HI, BUS_MACK_LO,
        BUS_MACK_HI, BUS_RTX_LO, BUS_RTX_HI, BUS_RACK_LO, BUS_RACK_HI
    } t_bus_step;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    i2crm_req_if req_ch ();
    i2crm_res_if res_ch ();

    i2c_register_master_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_res      (res_ch)
    );

    always #5 i_clk = ~i_clk;

    // Shadow configuration
    logic [DEV_ADDR_W-1:0]   dev_addr;
    logic [ADDR_BYTES_W-1:0] addr_len;

    // Shadow sequencer state
    t_bus_step             bus_step;
    logic [3:0]            bit_cnt;
    logic [BYTE_W-1:0]     shreg;
    logic [COUNT_W-1:0]    data_left;
    logic [1:0]            addr_left;
    logic [REG_ADDR_W-1:0] latched_reg;
    logic                  read_xfer;

    // Line states still owed by the block, oldest first
    t_res expected_lines[$];

    // Typed expectation travelling with the offered tick
    logic row_has_exp;
    t_res row_exp;

    bit tx_steady;
    int n_err, n_checked, n_items, n_reads, n_writes, n_rbytes, n_acks, n_stops;

    // One bus tick of the master
    function automatic t_res advance_bus(input t_req t);
        t_res r;
        int   n;
        r             = '0;
        r.scl         = 1'b1;
        r.sda_release = 1'b1;
        r.busy_res    = 1'b1;
        case (bus_step)
            BUS_TX_LO, BUS_RTX_LO: begin
                r.scl         = 1'b0;
                r.sda_release = shreg[7];
                if (bus_step == BUS_TX_LO) bus_step = BUS_TX_HI;
                else bus_step = BUS_RTX_HI;
            end
            BUS_TX_HI, BUS_RTX_HI: begin
                r.sda_release = shreg[7];
                shreg   = {shreg[6:0], 1'b0};
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt >= 4'd8) begin
                    if (bus_step == BUS_TX_HI) bus_step = BUS_ACK_LO;
                    else bus_step = BUS_RACK_LO;
                end else begin
                    if (bus_step == BUS_TX_HI) bus_step = BUS_TX_LO;
                    else bus_step = BUS_RTX_LO;
                end
            end
            BUS_ACK_LO, BUS_RACK_LO: begin
                r.scl = 1'b0;
                if (bus_step == BUS_ACK_LO) bus_step = BUS_ACK_HI;
                else bus_step = BUS_RACK_HI;
            end
            BUS_ACK_HI: begin
                r.ack_bit   = t.sda_in;
                r.ack_valid = 1'b1;
                // next register address byte, else on to data / restart / stop
                if (addr_left != 2'd0) begin
                    addr_left = addr_left - 2'd1;
                    shreg     = 8'(latched_reg >> (8 * addr_left));
                    bit_cnt   = 4'd0;
                    bus_step  = BUS_TX_LO;
                end else if (read_xfer) begin
                    bus_step = BUS_MSTOP_LO;
                end else if (data_left != '0) begin
                    bus_step = BUS_WAIT;
                end else begin
                    bus_step = BUS_STOP_LO;
                end
            end
            BUS_RACK_HI: begin
                r.ack_bit   = t.sda_in;
                r.ack_valid = 1'b1;
                bit_cnt     = 4'd0;
                shreg       = '0;
                if (data_left != '0) bus_step = BUS_RX_LO;
                else bus_step = BUS_STOP_LO;
            end
            BUS_WAIT: begin
                // SCL parked low until a byte turns up
                r.scl             = 1'b0;
                r.need_write_byte = 1'b1;
                if (t.write_valid) begin
                    shreg     = t.write_byte;
                    data_left = data_left - 16'd1;
                    bit_cnt   = 4'd0;
                    bus_step  = BUS_TX_LO;
                end
            end
            BUS_STOP_LO, BUS_MSTOP_LO: begin
                r.scl         = 1'b0;
                r.sda_release = 1'b0;
                if (bus_step == BUS_STOP_LO) bus_step = BUS_STOP_HI;
                else bus_step = BUS_MSTOP_HI;
            end
            BUS_STOP_HI, BUS_MSTOP_HI: begin
                r.sda_release = 1'b0;
                if (bus_step == BUS_STOP_HI) bus_step = BUS_STOP_END;
                else bus_step = BUS_MSTOP_END;
            end
            BUS_STOP_END: begin
                r.done_res = 1'b1;
                bus_step   = BUS_IDLE;
            end
            BUS_MSTOP_END: bus_step = BUS_RESTART;
            BUS_RESTART: begin
                r.sda_release = 1'b0;
                shreg         = {dev_addr, 1'b1};
                bit_cnt       = 4'd0;
                bus_step      = BUS_RTX_LO;
            end
            BUS_RX_LO: begin
                r.scl    = 1'b0;
                bus_step = BUS_RX_HI;
            end
            BUS_RX_HI: begin
                shreg   = {shreg[6:0], t.sda_in};
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt >= 4'd8) bus_step = BUS_MACK_LO;
                else bus_step = BUS_RX_LO;
            end
            BUS_MACK_LO: begin
                r.scl         = 1'b0;
                r.sda_release = (data_left == 16'd1);
                bus_step      = BUS_MACK_HI;
            end
            BUS_MACK_HI: begin
                // NAK on the final byte, ACK otherwise
                r.last_read   = (data_left == 16'd1);
                r.sda_release = r.last_read;
                r.read_byte   = shreg;
                r.read_valid  = 1'b1;
                data_left     = data_left - 16'd1;
                bit_cnt       = 4'd0;
                shreg         = '0;
                if (data_left == '0) bus_step = BUS_STOP_LO;
                else bus_step = BUS_RX_LO;
            end
            default: begin
                bus_step   = BUS_IDLE;
                r.busy_res = 1'b0;
                if (t.action == ACT_READ || t.action == ACT_WRITE) begin
                    r.busy_res    = 1'b1;
                    r.sda_release = 1'b0;
                    read_xfer     = (t.action == ACT_READ);
                    latched_reg   = t.reg_address;
                    data_left     = t.byte_count;
                    n             = int'(addr_len);
                    if (n > MAX_AB) n = MAX_AB;
                    addr_left     = n[1:0];
                    shreg         = {dev_addr, 1'b0};
                    bit_cnt       = 4'd0;
                    bus_step      = BUS_TX_LO;
                end
            end
        endcase
        return r;
    endfunction

    function automatic t_req mk_tick(input logic [ACTION_W-1:0] act,
                                     input logic [REG_ADDR_W-1:0] ra,
                                     input logic [COUNT_W-1:0] cnt,
                                     input logic [BYTE_W-1:0] wb,
                                     input logic wv, input logic sda);
        t_req t;
        t.action      = act;
        t.reg_address = ra;
        t.byte_count  = cnt;
        t.write_byte  = wb;
        t.write_valid = wv;
        t.sda_in      = sda;
        return t;
    endfunction

    function automatic t_res line_of(input logic scl, input logic rel,
                                     input logic busy, input logic nak);
        t_res r;
        r             = '0;
        r.scl         = scl;
        r.sda_release = rel;
        r.busy_res    = busy;
        r.ack_bit     = nak;
        r.ack_valid   = nak;
        return r;
    endfunction

    // Mostly short transfers, now and then a longer one
    function automatic logic [COUNT_W-1:0] pick_count();
        int p;
        p = $urandom_range(99);
        if (p < 70) return 16'($urandom_range(3));
        if (p < 95) return 16'($urandom_range(10, 4));
        return 16'($urandom_range(24, 11));
    endfunction

    // Random tick shaped by where the sequencer stands
    function automatic t_req make_tick();
        t_req t;
        t.action      = ACT_TICK;
        t.reg_address = 24'($urandom);
        t.byte_count  = 16'($urandom);
        t.write_byte  = 8'($urandom);
        t.write_valid = 1'($urandom_range(1));
        t.sda_in      = 1'($urandom_range(1));
        if ($urandom_range(99) < 8) begin
            t.action = 2'($urandom_range(3));
        end else if (bus_step == BUS_IDLE) begin
            if ($urandom_range(99) < 85)
                t.action = $urandom_range(1) ? ACT_READ : ACT_WRITE;
            else
                t.action = $urandom_range(1) ? ACT_TICK : ACT_RSVD;
        end else begin
            // actions while busy must be ignored
            if ($urandom_range(99) < 20) t.action = 2'($urandom_range(3));
            if (bus_step == BUS_WAIT) t.write_valid = ($urandom_range(99) < 75);
            if (bus_step == BUS_ACK_HI || bus_step == BUS_RACK_HI)
                t.sda_in = ($urandom_range(99) < 20);
        end
        // keep any transaction that actually starts short
        if (bus_step == BUS_IDLE && (t.action == ACT_READ || t.action == ACT_WRITE))
            t.byte_count = pick_count();
        return t;
    endfunction

    // Present one tick from a falling edge and hold it until taken
    task automatic offer(input t_req t, input logic has, input t_res e);
        while (!tx_steady && $urandom_range(99) < 15) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.action      <= t.action;
        req_ch.reg_address <= t.reg_address;
        req_ch.byte_count  <= t.byte_count;
        req_ch.write_byte  <= t.write_byte;
        req_ch.write_valid <= t.write_valid;
        req_ch.sda_in      <= t.sda_in;
        row_has_exp        <= has;
        row_exp            <= e;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
    endtask

    task automatic hold_until_drained();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (expected_lines.size() != 0) @(negedge i_clk);
    endtask

    // Finish the running transaction, then let the pipeline empty
    task automatic settle();
        t_req t;
        while (bus_step != BUS_IDLE) begin
            @(negedge i_clk);
            t             = make_tick();
            t.action      = ACT_TICK;
            t.write_valid = 1'b1;
            offer(t, 1'b0, '0);
        end
        hold_until_drained();
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        if (idx == CFG_DEVICE_ADDRESS) dev_addr = data[DEV_ADDR_W-1:0];
        else if (idx == CFG_REG_ADDRESS_BYTES) addr_len = data[ADDR_BYTES_W-1:0];
    endtask

    task automatic cmp_field(input string name, input logic [7:0] e, input logic [7:0] a);
        if (a !== e) begin
            n_err++;
            if (n_err <= 40)
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, e, a);
        end
    endtask

    task automatic compare_lines(input t_res e, input t_res a);
        cmp_field("scl", 8'(e.scl), 8'(a.scl));
        cmp_field("sda_release", 8'(e.sda_release), 8'(a.sda_release));
        cmp_field("read_byte", e.read_byte, a.read_byte);
        cmp_field("read_valid", 8'(e.read_valid), 8'(a.read_valid));
        cmp_field("last_read", 8'(e.last_read), 8'(a.last_read));
        cmp_field("ack_bit", 8'(e.ack_bit), 8'(a.ack_bit));
        cmp_field("ack_valid", 8'(e.ack_valid), 8'(a.ack_valid));
        cmp_field("need_write_byte", 8'(e.need_write_byte), 8'(a.need_write_byte));
        cmp_field("busy_res", 8'(e.busy_res), 8'(a.busy_res));
        cmp_field("done_res", 8'(e.done_res), 8'(a.done_res));
    endtask

    // Scoreboard: results checked first, then the tick taken this edge
    always @(posedge i_clk) begin : scoreboard_b
        t_res got;
        t_res pred;
        t_req tk;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                got = '{res_ch.scl, res_ch.sda_release, res_ch.read_byte, res_ch.read_valid,
                        res_ch.last_read, res_ch.ack_bit, res_ch.ack_valid,
                        res_ch.need_write_byte, res_ch.busy_res, res_ch.done_res};
                if (expected_lines.size() == 0) begin
                    n_err++;
                    if (n_err <= 40)
                        $display("%0t: result with nothing expected, expected none actual %h",
                                 $time, got);
                end else begin
                    compare_lines(expected_lines.pop_front(), got);
                    n_checked++;
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                tk = mk_tick(req_ch.action, req_ch.reg_address, req_ch.byte_count,
                             req_ch.write_byte, req_ch.write_valid, req_ch.sda_in);
                pred = advance_bus(tk);
                if (pred.read_valid) n_rbytes++;
                if (pred.ack_valid) n_acks++;
                if (pred.done_res) n_stops++;
                if (row_has_exp) expected_lines.push_back(row_exp);
                else expected_lines.push_back(pred);
            end
        end
    end

    // Result side: random stalls, a periodic long hold-off and a clean stretch
    initial begin : receiver_b
        int rx_cyc;
        int ph;
        rx_cyc       = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rx_cyc++;
            ph = rx_cyc % 1000;
            if (ph >= 300 && ph < 360) res_ch.ready <= 1'b0;
            else if (ph >= 500 && ph < 800) res_ch.ready <= 1'b1;
            else res_ch.ready <= ($urandom_range(99) >= 15);
        end
    end

    initial begin : watchdog_b
        #(2_000_000);
        $display("%0t: run did not complete in time", $time);
        $display("CHECKS FAILED");
        $finish;
    end

    // Stimulus
    initial begin : stim_b
        t_req                  dir_req [DIR_N];
        logic                  dir_chk [DIR_N];
        t_res                  dir_res [DIR_N];
        t_req                  t;
        logic [DEV_ADDR_W-1:0] ph_dev [PHASES];
        logic [1:0]            ph_len [PHASES];
        logic [CFG_DATA_W-1:0] cv;
        int                    target;

        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_data           = '0;
        req_ch.valid       = 1'b0;
        req_ch.action      = ACT_TICK;
        req_ch.reg_address = '0;
        req_ch.byte_count  = '0;
        req_ch.write_byte  = '0;
        req_ch.write_valid = 1'b0;
        req_ch.sda_in      = 1'b0;
        row_has_exp        = 1'b0;
        row_exp            = '0;
        tx_steady          = 1'b0;
        n_err = 0; n_checked = 0; n_items = 0; n_reads = 0; n_writes = 0;
        n_rbytes = 0; n_acks = 0; n_stops = 0;

        // state after reset
        dev_addr    = '0;
        addr_len    = 2'd1;
        bus_step    = BUS_IDLE;
        bit_cnt     = '0;
        shreg       = '0;
        data_left   = '0;
        addr_left   = '0;
        latched_reg = '0;
        read_xfer   = 1'b0;

        // directed table: idle ticks, reserved action, zero-length write, busy actions
        dir_req[0] = mk_tick(ACT_TICK, 24'h000000, 16'h0000, 8'h00, 1'b0, 1'b0);
        dir_req[1] = mk_tick(ACT_RSVD, 24'hFFFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
        dir_req[2] = mk_tick(ACT_WRITE, 24'hA5C3FF, 16'h0000, 8'h00, 1'b0, 1'b0);
        for (int i = 3; i < DIR_N; i++) begin
            dir_req[i] = mk_tick((i % 3 == 0) ? ACT_READ : ((i % 3 == 1) ? ACT_WRITE : ACT_RSVD),
                                 i[0] ? 24'hFFFFFF : 24'h000000, i[0] ? 16'hFFFF : 16'h0000,
                                 i[0] ? 8'hFF : 8'h00, i[0], ~i[0]);
        end
        for (int i = 0; i < DIR_N; i++) dir_chk[i] = 1'b0;
        dir_chk[0] = 1'b1; dir_res[0] = line_of(1'b1, 1'b1, 1'b0, 1'b0);
        dir_chk[1] = 1'b1; dir_res[1] = line_of(1'b1, 1'b1, 1'b0, 1'b0);
        dir_chk[2] = 1'b1; dir_res[2] = line_of(1'b1, 1'b0, 1'b1, 1'b0);  // START
        dir_chk[3] = 1'b1; dir_res[3] = line_of(1'b0, 1'b0, 1'b1, 1'b0);  // addr MSB of 0
        dir_chk[20] = 1'b1; dir_res[20] = line_of(1'b1, 1'b1, 1'b1, 1'b1); // NAK reported

        // address settings per phase, extremes first
        ph_dev[0] = 7'd0;             ph_len[0] = 2'd1;
        ph_dev[1] = 7'h7F;            ph_len[1] = 2'd3;
        ph_dev[2] = 7'h00;            ph_len[2] = 2'd0;
        ph_dev[3] = 7'h55;            ph_len[3] = 2'd2;
        ph_dev[4] = 7'($urandom);     ph_len[4] = 2'd1;
        ph_dev[5] = 7'($urandom);     ph_len[5] = 2'($urandom_range(3));

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++) begin
            @(negedge i_clk);
            offer(dir_req[i], dir_chk[i], dir_res[i]);
        end

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                settle();
                write_cfg(CFG_DEVICE_ADDRESS, ph_dev[p]);
                cv = 7'($urandom);
                cv[ADDR_BYTES_W-1:0] = ph_len[p];
                write_cfg(CFG_REG_ADDRESS_BYTES, cv);
            end
            target = n_items + PHASE_IT;
            while (n_items < target) begin
                // sender pauses once until the pipeline is empty
                if (p == 2 && n_items == target - PHASE_IT / 2) hold_until_drained();
                tx_steady = (n_items >= 600 && n_items < 900);
                @(negedge i_clk);
                t = make_tick();
                if (bus_step == BUS_IDLE && t.action == ACT_READ) n_reads++;
                if (bus_step == BUS_IDLE && t.action == ACT_WRITE) n_writes++;
                if (bus_step != BUS_IDLE || t.action == ACT_READ || t.action == ACT_WRITE)
                    n_items++;
                offer(t, 1'b0, '0);
            end
        end

        settle();
        repeat (8) @(negedge i_clk);

        $display("Covered %0d reads and %0d writes over %0d address settings, %0d ticks checked",
                 n_reads, n_writes, PHASES, n_checked);
        $display("%0d bytes read back, %0d slave acknowledge samples, %0d final STOPs",
                 n_rbytes, n_acks, n_stops);
        if (n_err == 0 && expected_lines.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/i2crm_pkg.sv
rtl/i2crm_channels_if.sv
rtl/i2crm_in_stage.sv
rtl/i2crm_sequencer.sv
rtl/i2c_register_master_top.sv
tb/i2c_register_master_top_tb.sv
